// ===== rtl/mtg_pkg.sv =====
// Shared types, constants and word functions of the MT19937 generator.
package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned OFFSET      = 397;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam addr_t LAST_IDX     = addr_t'(STATE_WORDS - 1);
  localparam addr_t TWIST_OFFSET = addr_t'(OFFSET);
  localparam addr_t FAR_WRAP     = addr_t'(STATE_WORDS - OFFSET);

  localparam word_t TWIST_MATRIX = 32'h9908_B0DF;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;
  localparam word_t LCG_MULT     = 32'd69069;
  localparam word_t DEFAULT_SEED = 32'h0000_1105;

  // LCG sequencing controls, top level to seeding unit
  typedef struct packed {
    logic load;     // take a fresh seed into x
    logic step_a;   // x1 <= x * A + 1
    logic step_b;   // x  <= x1 * A + 1
  } lcg_ctl_t;

  // One twist step: upper bit of cur, lower bits of nxt, folded with far word
  function automatic word_t mix_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t r;
    y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
    r = (y >> 1) ^ far;
    if (y[0]) begin
      r = r ^ TWIST_MATRIX;
    end
    return r;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t v;
    v = w;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

// ===== rtl/mtg_ram.sv =====
// State word memory: one write port, one registered read port.
module mtg_ram import mtg_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  word_t wdata,
  input  addr_t raddr,
  output word_t rdata
);

  word_t mem [STATE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mtg_lcg.sv =====
// Seeding unit: 69069*x+1 congruential steps, one shared multiplier.
module mtg_lcg import mtg_pkg::*; (
  input  logic     clk,
  input  lcg_ctl_t ctl,
  input  word_t    seed_value,
  output word_t    seed_word
);

  word_t x;
  word_t x1;
  word_t mul_in;
  word_t step;

  // second step of a pair works from x1
  assign mul_in = ctl.step_b ? x1 : x;
  assign step   = mul_in * LCG_MULT + 32'd1;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= seed_value;
    end else if (ctl.step_a) begin
      x1 <= step;
    end else if (ctl.step_b) begin
      x <= step;
    end
  end

  // high halves of two successive values
  assign seed_word = {x[WORD_W-1:WORD_W/2], x1[WORD_W-1:WORD_W/2]};

endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// MT19937 generator top level: request sequencer, lazy twist and tempering.
//
//  channel | handshake          | payload        | notes
//  --------+--------------------+----------------+-------------------------------
//  in      | in_valid/in_stall  | mode, seed     | mode 0 seeds, mode 1 draws
//  out     | out_valid/out_stall| random_word    | one word per draw request
//
// A draw steps through accept, three reads of the single memory read port
// (current word, next word, word 397 ahead), then twist, write back and temper.
// A seed writes all 624 words, with two LCG steps per word through one
// multiplier. A draw before any seed runs the seed sequence with 4357 first.
// rst (synchronous) clears control only; memory contents are written by seeding.
// A stalled output holds the last draw in its final cycle until taken.
module mersenne_twister_generator import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED_A = 3'd1;
  localparam logic [2:0] ST_SEED_B = 3'd2;
  localparam logic [2:0] ST_RD_CUR = 3'd3;
  localparam logic [2:0] ST_RD_NXT = 3'd4;
  localparam logic [2:0] ST_RD_FAR = 3'd5;
  localparam logic [2:0] ST_MIX    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  addr_t      pos;        // next word to twist and draw
  addr_t      seed_idx;
  logic       seeded;
  logic       pend_draw;  // draw waiting on the default seed
  word_t      cur;
  word_t      nxt;

  logic       accept;
  logic       out_free;
  addr_t      pos_inc;
  addr_t      far_idx;
  lcg_ctl_t   lcg_ctl;
  word_t      lcg_seed;
  word_t      seed_word;
  logic       we;
  addr_t      waddr;
  word_t      wdata;
  addr_t      raddr;
  word_t      rdata;
  word_t      mixed;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pos_inc = (pos == LAST_IDX) ? '0 : pos + addr_t'(1);
  // in-place twist: words below the wrap see old far words, later ones new
  assign far_idx = (pos < FAR_WRAP) ? pos + TWIST_OFFSET : pos - FAR_WRAP;

  assign lcg_seed       = (accept && !mode) ? seed : DEFAULT_SEED;
  assign lcg_ctl.load   = accept && (!mode || !seeded);
  assign lcg_ctl.step_a = (state == ST_SEED_A);
  assign lcg_ctl.step_b = (state == ST_SEED_B);

  mtg_lcg u_lcg (
    .clk        (clk),
    .ctl        (lcg_ctl),
    .seed_value (lcg_seed),
    .seed_word  (seed_word)
  );

  assign mixed = mix_word(cur, nxt, rdata);

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = mixed;
    if (state == ST_SEED_B) begin
      we    = 1'b1;
      waddr = seed_idx;
      wdata = seed_word;
    end else if ((state == ST_MIX) && out_free) begin
      we = 1'b1;
    end
  end

  always_comb begin
    unique case (state)
      ST_RD_NXT: raddr = pos_inc;
      ST_RD_FAR: raddr = far_idx;
      ST_MIX:    raddr = far_idx;   // hold far word across an output stall
      default:   raddr = pos;
    endcase
  end

  mtg_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (mode && seeded) ? ST_RD_CUR : ST_SEED_A;
        end
      end
      ST_SEED_A: state_next = ST_SEED_B;
      ST_SEED_B: begin
        if (seed_idx == LAST_IDX) begin
          state_next = pend_draw ? ST_RD_CUR : ST_IDLE;
        end else begin
          state_next = ST_SEED_A;
        end
      end
      ST_RD_CUR: state_next = ST_RD_NXT;
      ST_RD_NXT: state_next = ST_RD_FAR;
      ST_RD_FAR: state_next = ST_MIX;
      ST_MIX: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      seed_idx  <= '0;
      seeded    <= 1'b0;
      pend_draw <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        seed_idx  <= '0;
        pend_draw <= mode && !seeded;
      end
      if (state == ST_SEED_B) begin
        seed_idx <= seed_idx + addr_t'(1);
        if (seed_idx == LAST_IDX) begin
          pos       <= '0;
          seeded    <= 1'b1;
          pend_draw <= 1'b0;
        end
      end
      if ((state == ST_MIX) && out_free) begin
        pos       <= pos_inc;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_RD_NXT) begin
      cur <= rdata;
    end
    if (state == ST_RD_FAR) begin
      nxt <= rdata;
    end
    if ((state == ST_MIX) && out_free) begin
      random_word <= temper(mixed);
    end
  end

endmodule

// ===== rtl/mtg_checker.sv =====
// Port-level checks of the generator, bound to the top level.
module mtg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] random_word
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_word))
    else $error("stalled result changed");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // a seed request yields no result
  a_seed_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !mode && !out_valid |=> !out_valid)
    else $error("result after seed request");

  // a result only appears at the end of request work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result with no request in progress");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .mode        (mode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .random_word (random_word)
);

// ===== tb/mersenne_twister_generator_tb.sv =====
// Self-checking testbench for the MT19937 generator: seed and draw requests against a predictor.
module mersenne_twister_generator_tb import mtg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes on the mode field
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam int unsigned NEVER_SEEDED  = STATE_WORDS + 1;
  localparam int          RANDOM_COUNT  = 1875;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          HOLD_AT       = 240;   // requests sent before the long hold-off
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 1300;  // covers a seed still running at the end
  localparam int          REPORT_LIMIT  = 10;

  // Predicts every draw and holds the words still owed by the block.
  class draw_scoreboard;
    word_t       words[STATE_WORDS];
    int unsigned position;
    word_t       owed_words[$];
    int unsigned mismatches;

    function new();
      foreach (words[k]) words[k] = '0;
      position   = NEVER_SEEDED;
      mismatches = 0;
    endfunction

    // Old-style seeding: two LCG steps per word, high halves only
    function void load_seed(word_t s);
      word_t x;
      word_t hi;
      x = s;
      for (int k = 0; k < STATE_WORDS; k++) begin
        hi = x & 32'hFFFF_0000;
        x = x * LCG_MULT + 32'd1;
        words[k] = hi | (x >> 16);
        x = x * LCG_MULT + 32'd1;
      end
      position = STATE_WORDS;
    endfunction

    // In-place regeneration; later words see the already updated far words
    function void regenerate();
      word_t y;
      word_t r;
      int unsigned nxt;
      int unsigned far_idx;
      for (int unsigned k = 0; k < STATE_WORDS; k++) begin
        nxt     = (k + 1) % STATE_WORDS;
        far_idx = (k + OFFSET) % STATE_WORDS;
        y = {words[k][31], words[nxt][30:0]};
        r = (y >> 1) ^ words[far_idx];
        if (y[0]) begin
          r = r ^ TWIST_MATRIX;
        end
        words[k] = r;
      end
      position = 0;
    endfunction

    function word_t scramble(word_t w);
      word_t v;
      v = w;
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & TEMPER_B);
      v = v ^ ((v << 15) & TEMPER_C);
      v = v ^ (v >> 18);
      return v;
    endfunction

    function void note_request(logic m, word_t s);
      word_t v;
      if (m == MODE_SEED) begin
        load_seed(s);
      end else begin
        if (position >= STATE_WORDS) begin
          if (position == NEVER_SEEDED) begin
            load_seed(DEFAULT_SEED);
          end
          regenerate();
        end
        v = words[position % STATE_WORDS];
        position = (position + 1) & 32'h3FF;
        owed_words.push_back(scramble(v));
      end
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected word %08h at %0t", got, $realtime);
        end
      end else begin
        want = owed_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("random_word mismatch: expected %08h got %08h at %0t", want, got,
                     $realtime);
          end
        end
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  mode = MODE_SEED;
  word_t seed = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t random_word;

  draw_scoreboard board;
  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  int  requests_sent      = 0;
  int  cycle_count        = 0;
  logic hold_off          = 1'b0;

  mersenne_twister_generator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .seed        (seed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one request and wait for it to be taken. Idle cycles go in front, so
  // valid is only ever dropped or kept in the step of the previous acceptance.
  task automatic offer_request(input logic m, input word_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    seed     <= s;
    do @(posedge clk); while (in_stall);
    board.note_request(m, s);
    requests_sent++;
  endtask

  // Receiver: check on the pre-edge values, then decide the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_word(random_word);
    end
    out_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
  end

  // Long receiver hold-off while draws keep coming: the block must back up
  // and stall its input side
  initial begin
    wait (requests_sent >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mersenne_twister_generator_tb: done, errors");
    $finish;
  end

  initial begin
    int   draws_left;
    int   segment;
    word_t fresh_seed;

    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first draw straight after reset takes the default seed path.
    offer_request(MODE_DRAW, 32'h0000_0000);
    offer_request(MODE_DRAW, 32'hFFFF_FFFF);
    offer_request(MODE_DRAW, 32'h0000_0000);
    // extremes of the seed field
    offer_request(MODE_SEED, 32'h0000_0000);
    offer_request(MODE_DRAW, 32'hFFFF_FFFF);
    offer_request(MODE_DRAW, 32'h1234_5678);
    offer_request(MODE_SEED, 32'hFFFF_FFFF);
    offer_request(MODE_DRAW, 32'h0000_0000);
    // back-to-back seeds: only the second one counts
    offer_request(MODE_SEED, 32'h8000_0000);
    offer_request(MODE_SEED, 32'h0000_0001);
    offer_request(MODE_DRAW, 32'h0000_0000);
    offer_request(MODE_DRAW, 32'hFFFF_FFFF);
    // explicit seed equal to the default one
    offer_request(MODE_SEED, DEFAULT_SEED);
    offer_request(MODE_DRAW, 32'hDEAD_BEEF);
    offer_request(MODE_SEED, 32'hAAAA_AAAA);
    offer_request(MODE_SEED, 32'h5555_5555);
    offer_request(MODE_DRAW, 32'h0000_0000);

    // Random part: long draw runs with the odd reseed. The first run is long
    // enough to use up all words and force a regeneration mid-stream.
    draws_left = 700;
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      segment = (i * 5) / RANDOM_COUNT;
      case (segment)
        1: begin
          sender_idle_pct    = 58;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 58;
        end
        3: begin
          sender_idle_pct    = 24;
          receiver_stall_pct = 24;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      if (draws_left == 0) begin
        fresh_seed = $urandom;
        offer_request(MODE_SEED, fresh_seed);
        draws_left = $urandom_range(1400, 1);
      end else begin
        offer_request(MODE_DRAW, $urandom);
        draws_left--;
      end
    end
    in_valid <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    // Drain, then give a trailing seed time to finish without stray output
    while (board.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.owed_words.size() == 0) begin
      $display("mersenne_twister_generator_tb: done, clean");
    end else begin
      $display("mersenne_twister_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
